// File: hdl/dcs_pkg.sv
// shared widths and constants of the drift coefficient stencil unit
package dcs_pkg;

  localparam int unsigned NumDirs   = 8;
  localparam int unsigned DiffW     = 24;
  localparam int unsigned CoefW     = 22;
  localparam int unsigned CenterW   = 25;
  localparam int unsigned DenW      = 48;
  localparam int unsigned ProdW     = 40;

  // 1/sqrt(2) as a q0.16 fraction
  localparam logic [15:0] InvSqrt2  = 16'd46341;
  localparam logic [ProdW-1:0] HalfQ16 = ProdW'(32768);

  // coef = 995000*m / (11*(1000000*m + 95*2^f))
  localparam logic [DenW-1:0] NumScale = DenW'(995000);
  localparam logic [DenW-1:0] DenScale = DenW'(1000000);
  localparam logic [DenW-1:0] DenOff   = DenW'(95);

  // lanes that hold a diagonal neighbor: up_left, up_right, down_left, down_right
  localparam logic [NumDirs-1:0] CornerMask = 8'b1010_0101;

endpackage

// File: hdl/dcs_prep.sv
// magnitude, corner scaling and fraction operands of one direction, three stages
module dcs_prep #(
  parameter int unsigned DiffFracBits = 20,
  parameter bit          IsCorner     = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [dcs_pkg::DiffW-1:0]     diff_i,
  output logic [dcs_pkg::DenW-1:0]      num_o,
  output logic [dcs_pkg::DenW-1:0]      den_o
);

  logic [dcs_pkg::DiffW-1:0] mag;
  logic [dcs_pkg::ProdW-1:0] scaled;
  logic [dcs_pkg::DiffW-1:0] m_d, m_q;
  logic [dcs_pkg::DenW-1:0]  num2_d, num2_q, den2_d, den2_q;
  logic [dcs_pkg::DenW-1:0]  num3_q, den3_d, den3_q;

  // stage 1: magnitude of a negative difference, diagonal scaled by 1/sqrt(2)
  always_comb begin
    mag    = diff_i[dcs_pkg::DiffW-1] ? (~diff_i + dcs_pkg::DiffW'(1)) : '0;
    scaled = dcs_pkg::ProdW'(mag) * dcs_pkg::ProdW'(dcs_pkg::InvSqrt2) + dcs_pkg::HalfQ16;
    m_d    = IsCorner ? scaled[dcs_pkg::DiffW+15:16] : mag;
  end

  // stage 2: numerator and unscaled denominator
  always_comb begin
    num2_d = dcs_pkg::DenW'(m_q) * dcs_pkg::NumScale;
    den2_d = dcs_pkg::DenW'(m_q) * dcs_pkg::DenScale + (dcs_pkg::DenOff << DiffFracBits);
  end

  // stage 3: denominator times eleven
  always_comb begin
    den3_d = (den2_q << 3) + (den2_q << 1) + den2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      num2_q <= num2_d;
      den2_q <= den2_d;
      num3_q <= num2_q;
      den3_q <= den3_d;
    end
  end

  assign num_o = num3_q;
  assign den_o = den3_q;

endmodule

// File: hdl/dcs_div.sv
// pipelined restoring fraction divider, one quotient bit per stage
module dcs_div #(
  parameter int unsigned CoefFracBits = 24
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dcs_pkg::DenW-1:0]    num_i,
  input  logic [dcs_pkg::DenW-1:0]    den_i,
  output logic [CoefFracBits:0]       q_o
);

  localparam int unsigned Steps = CoefFracBits + 1;

  logic [dcs_pkg::DenW-1:0] rem_q [Steps];
  logic [dcs_pkg::DenW-1:0] den_q [Steps];
  logic [Steps-1:0]         q_q   [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [dcs_pkg::DenW-1:0] rem_in, den_in, rem_sh, rem_d;
    logic [Steps-1:0]         q_in, q_d;
    logic                     ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign q_in   = q_q[s-1];
    end

    // shift, compare and subtract
    always_comb begin
      rem_sh = {rem_in[dcs_pkg::DenW-2:0], 1'b0};
      ge     = (rem_sh >= den_in);
      rem_d  = ge ? (rem_sh - den_in) : rem_sh;
      q_d    = {q_in[Steps-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        q_q[s]   <= q_d;
      end
    end
  end

  assign q_o = q_q[Steps-1];

endmodule

// File: hdl/drift_coefficient_stencil_unit.sv
// top level of the drift coefficient stencil unit
//
// one input word carries the eight height differences of a 3x3 neighborhood
// (neighbor minus center, signed, DIFF_FRAC_BITS fraction bits); one output
// word carries the eight flow coefficients and the center coefficient, which
// is the negated sum of the eight. both channels use valid/ready and a word
// moves when valid and ready are high at the same rising edge.
// the pipeline has three operand stages, one stage per quotient bit of the
// divider chain, a rounding stage and the output register with the center sum.
// throughput is one word per cycle while the receiver does not stall; the
// divider chain is fully pipelined.
// when the receiver stalls the whole pipeline holds in place and in_ready_o
// drops, so nothing is lost or repeated; in_ready_o is high whenever the
// output register is empty or being read.
// reset (rst_ni low, asynchronous) clears all valid bits; the pipeline is
// empty and ready as soon as reset is released.
module drift_coefficient_stencil_unit #(
  parameter int unsigned DIFF_FRAC_BITS = 20,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_up_left_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_up_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_up_right_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_left_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_right_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_down_left_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_down_i,
  input  logic signed [dcs_pkg::DiffW-1:0]     diff_down_right_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dcs_pkg::CoefW-1:0]            coef_up_left_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_up_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_up_right_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_left_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_right_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_down_left_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_down_o,
  output logic [dcs_pkg::CoefW-1:0]            coef_down_right_o,
  output logic signed [dcs_pkg::CenterW-1:0]   coef_center_o
);

  localparam int unsigned Steps = COEF_FRAC_BITS + 1;
  localparam int unsigned Depth = Steps + 5;
  localparam int unsigned SumW  = (COEF_FRAC_BITS + 4 > dcs_pkg::CenterW) ?
                                  COEF_FRAC_BITS + 4 : dcs_pkg::CenterW;

  logic                         en;
  logic [Depth-1:0]             vld_q;
  logic [dcs_pkg::DiffW-1:0]    diff_a [dcs_pkg::NumDirs];
  logic [COEF_FRAC_BITS:0]      q_a    [dcs_pkg::NumDirs];
  logic [SumW-1:0]              cr_q   [dcs_pkg::NumDirs];
  logic [dcs_pkg::CoefW-1:0]    coef_q [dcs_pkg::NumDirs];
  logic [SumW-1:0]              sum;
  logic [dcs_pkg::CenterW-1:0]  center_d, center_q;

  // pipeline advances unless a finished word waits on a stalled receiver
  assign en         = ~vld_q[Depth-1] | out_ready_i;
  assign in_ready_o = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // input lanes in field order
  always_comb begin
    diff_a[0] = diff_up_left_i;
    diff_a[1] = diff_up_i;
    diff_a[2] = diff_up_right_i;
    diff_a[3] = diff_left_i;
    diff_a[4] = diff_right_i;
    diff_a[5] = diff_down_left_i;
    diff_a[6] = diff_down_i;
    diff_a[7] = diff_down_right_i;
  end

  // one operand stage set and one divider chain per direction
  for (genvar d = 0; d < dcs_pkg::NumDirs; d++) begin : g_lane
    logic [dcs_pkg::DenW-1:0] num, den;
    logic [COEF_FRAC_BITS+1:0] rnd;

    dcs_prep #(
      .DiffFracBits (DIFF_FRAC_BITS),
      .IsCorner     (dcs_pkg::CornerMask[d])
    ) u_prep (
      .clk_i  (clk_i),
      .en_i   (en),
      .diff_i (diff_a[d]),
      .num_o  (num),
      .den_o  (den)
    );

    dcs_div #(
      .CoefFracBits (COEF_FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num),
      .den_i (den),
      .q_o   (q_a[d])
    );

    // round half up from the extra quotient bit
    assign rnd = ({1'b0, q_a[d]} + (COEF_FRAC_BITS+2)'(1)) >> 1;

    always_ff @(posedge clk_i) begin
      if (en) begin
        cr_q[d]   <= SumW'(rnd);
        coef_q[d] <= cr_q[d][dcs_pkg::CoefW-1:0];
      end
    end
  end

  // center coefficient: negated sum of the eight
  always_comb begin
    sum = '0;
    for (int i = 0; i < dcs_pkg::NumDirs; i++) begin
      sum = sum + cr_q[i];
    end
    center_d = dcs_pkg::CenterW'(SumW'(0) - sum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      center_q <= center_d;
    end
  end

  assign out_valid_o       = vld_q[Depth-1];
  assign coef_up_left_o    = coef_q[0];
  assign coef_up_o         = coef_q[1];
  assign coef_up_right_o   = coef_q[2];
  assign coef_left_o       = coef_q[3];
  assign coef_right_o      = coef_q[4];
  assign coef_down_left_o  = coef_q[5];
  assign coef_down_o       = coef_q[6];
  assign coef_down_right_o = coef_q[7];
  assign coef_center_o     = center_q;

`ifndef SYNTH
  // a stalled pipeline keeps every valid bit where it is
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // a word accepted while the pipeline runs shows up in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted word not captured");

  // the center coefficient is never positive
  a_center_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coef_center_o[dcs_pkg::CenterW-1] || coef_center_o == '0))
    else $error("center coefficient positive");

  // the up neighbor coefficient never exceeds one eighth
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coef_up_o <= dcs_pkg::CoefW'(2097152)))
    else $error("neighbor coefficient out of range");
`endif

endmodule

// File: test/dcs_checker.sv
// checker for the drift coefficient stencil unit: predicts and compares each output word
`timescale 1ns / 100ps

module dcs_checker #(
  parameter int unsigned DIFF_FRAC_BITS = 20,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [dcs_pkg::DiffW-1:0]       diff_i [dcs_pkg::NumDirs],
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic [dcs_pkg::CoefW-1:0]              coef_i [dcs_pkg::NumDirs],
  input  logic signed [dcs_pkg::CenterW-1:0]     center_i,
  output int                                     errors_o,
  output int                                     pending_o
);

  typedef struct {
    logic [dcs_pkg::CoefW-1:0]          coef [dcs_pkg::NumDirs];
    logic signed [dcs_pkg::CenterW-1:0] center;
  } coef_word_t;

  coef_word_t expected_q [$];

  // drift coefficient of one neighbor difference
  function automatic logic [63:0] drift_coef(logic [dcs_pkg::DiffW-1:0] raw, bit corner);
    logic [63:0] mag, num, den, rem, quo;
    if (!raw[dcs_pkg::DiffW-1]) return 64'd0;
    mag = 64'(25'h1000000 - {1'b0, raw});
    if (corner) mag = (mag * 64'd46341 + 64'd32768) >> 16;
    if (mag == 0) return 64'd0;
    num = 64'd995000 * mag;
    den = 64'd11 * (64'd1000000 * mag + (64'd95 << DIFF_FRAC_BITS));
    rem = num;
    quo = 0;
    // long division for coef_frac_bits+1 fraction bits
    for (int i = 0; i < COEF_FRAC_BITS + 1; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return (quo + 1) >> 1;
  endfunction

  function automatic coef_word_t predict_coefs(logic [dcs_pkg::DiffW-1:0] d [dcs_pkg::NumDirs]);
    coef_word_t w;
    logic [63:0] c, total;
    total = 0;
    for (int i = 0; i < dcs_pkg::NumDirs; i++) begin
      c = drift_coef(d[i], dcs_pkg::CornerMask[i]);
      w.coef[i] = c[dcs_pkg::CoefW-1:0];
      total += c;
    end
    w.center = dcs_pkg::CenterW'(64'd0 - total);
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;
  initial pending_o = 0;

  // capture accepted input words
  always @(posedge clk_i) begin
    logic [dcs_pkg::DiffW-1:0] d [dcs_pkg::NumDirs];
    if (rst_ni && in_valid_i && in_ready_i) begin
      for (int i = 0; i < dcs_pkg::NumDirs; i++) d[i] = diff_i[i];
      expected_q.push_back(predict_coefs(d));
      pending_o = expected_q.size();
    end
  end

  // compare accepted output words
  always @(posedge clk_i) begin
    coef_word_t w;
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = expected_q.pop_front();
        pending_o = expected_q.size();
        for (int i = 0; i < dcs_pkg::NumDirs; i++)
          if (coef_i[i] !== w.coef[i])
            report_mismatch($sformatf("coef lane %0d", i), coef_i[i], w.coef[i]);
        if (center_i !== w.center) report_mismatch("center", center_i, w.center);
      end
    end
  end

endmodule

// File: test/tb_top.sv
// testbench top of the drift coefficient stencil unit: stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int Latency = 30;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 0;
  logic signed [dcs_pkg::DiffW-1:0] diff [dcs_pkg::NumDirs];
  logic [dcs_pkg::CoefW-1:0] coef [dcs_pkg::NumDirs];
  logic signed [dcs_pkg::CenterW-1:0] center;
  int errors, pending;
  int burst_left = 0;

  initial for (int i = 0; i < dcs_pkg::NumDirs; i++) diff[i] = '0;

  always #4 clk_i = ~clk_i;

  drift_coefficient_stencil_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .diff_up_left_i(diff[0]), .diff_up_i(diff[1]), .diff_up_right_i(diff[2]),
    .diff_left_i(diff[3]), .diff_right_i(diff[4]), .diff_down_left_i(diff[5]),
    .diff_down_i(diff[6]), .diff_down_right_i(diff[7]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .coef_up_left_o(coef[0]), .coef_up_o(coef[1]), .coef_up_right_o(coef[2]),
    .coef_left_o(coef[3]), .coef_right_o(coef[4]), .coef_down_left_o(coef[5]),
    .coef_down_o(coef[6]), .coef_down_right_o(coef[7]), .coef_center_o(center)
  );

  dcs_checker chk (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready), .diff_i(diff),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .coef_i(coef),
    .center_i(center), .errors_o(errors), .pending_o(pending)
  );

  // receiver stall pattern: phases of full speed, light and heavy stalling
  always @(posedge clk_i) begin
    int phase;
    phase = int'(($time / 2000) % 3);
    if (phase == 0) out_ready <= 1'b1;
    else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  // random difference, mostly negative, from all scales
  function automatic logic [dcs_pkg::DiffW-1:0] rand_diff();
    case ($urandom_range(0, 7))
      0:       return dcs_pkg::DiffW'($urandom);
      1:       return -dcs_pkg::DiffW'($urandom_range(1, 4));
      2:       return -dcs_pkg::DiffW'($urandom_range(1, 2000));
      3:       return dcs_pkg::DiffW'($urandom_range(0, 5));
      4:       return {1'b1, 23'($urandom)};
      5:       return 24'h800000;
      default: return -dcs_pkg::DiffW'($urandom_range(1, 200000));
    endcase
  endfunction

  // present one word, with an idle gap before each burst
  task automatic send_word(logic [dcs_pkg::DiffW-1:0] d [dcs_pkg::NumDirs]);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    for (int i = 0; i < dcs_pkg::NumDirs; i++) diff[i] <= d[i];
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    logic [dcs_pkg::DiffW-1:0] d [dcs_pkg::NumDirs];
    logic [dcs_pkg::DiffW-1:0] corners [10];
    int waited;
    corners = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFE,
                24'hFFFFFD, 24'h000001, 24'hFFF000, 24'hF00000, 24'hAAAAAA};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each extreme on all lanes, then rotated mixes
    for (int k = 0; k < 10; k++) begin
      for (int i = 0; i < dcs_pkg::NumDirs; i++) d[i] = corners[k];
      send_word(d);
    end
    for (int k = 0; k < 10; k++) begin
      for (int i = 0; i < dcs_pkg::NumDirs; i++) d[i] = corners[(k + i) % 10];
      send_word(d);
    end
    // random words
    for (int n = 0; n < 500; n++) begin
      for (int i = 0; i < dcs_pkg::NumDirs; i++) d[i] = rand_diff();
      send_word(d);
    end
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hdl/dcs_pkg.sv
hdl/dcs_prep.sv
hdl/dcs_div.sv
hdl/drift_coefficient_stencil_unit.sv
test/dcs_checker.sv
test/tb_top.sv
